// ===== hdl/bdq_pkg.sv =====
// Shared constants, command and status codes, and control types for the bounded deque.
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 8;

   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 4;
   localparam int REQ_DATA_W = ((CMD_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VALUE_W + STATUS_W + OCC_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
   } ctrl_type;

endpackage

// ===== hdl/bounded_deque.sv =====
// Top level of the bounded deque: request and response stream channels.
//
// A bounded double-ended queue of signed 32-bit words, DEPTH words deep.
// Each request word carries a command (push front, push back, pop front,
// pop back) and a value; each request gives exactly one response word with
// the popped value, a status and the occupancy after the command.
// A push into a full deque is refused with status full and changes nothing;
// a pop from an empty deque returns zero with status empty.
//
// A request is executed when accepted. Its popped word passes through the
// registered read port of the word store, and its status and occupancy
// through their own registers, into the result register that drives the
// response; no new request is accepted until that result is loaded. Words
// are kept in a circular store with a front pointer and a count.
//
// Reset clears the pointer, the count and the pending response; the store
// itself needs no clearing. While the receiver stalls, the response holds in
// the result register and one further request may be accepted and executed;
// its response then waits until the register drains.
module bounded_deque #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bdq_pkg::REQ_DATA_W-1:0]  req_tdata,  // command[1:0], push_value[33:2]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bdq_pkg::RSP_DATA_W-1:0]  rsp_tdata   // pop_value[31:0], status[33:32],
                                                       // occupancy[37:34]
);
   import bdq_pkg::*;

   ctrl_type                   ctrl;
   cmd_type                    req_cmd;
   logic signed [VALUE_W-1:0]  req_value;

   assign req_cmd   = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_value = req_tdata[CMD_W+VALUE_W-1:CMD_W];

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   bdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== hdl/bdq_ctrl.sv =====
// Controller state machine: sequences request acceptance and result loading.
module bdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output bdq_pkg::ctrl_type ctrl
);
   import bdq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready  = (state_ff == ST_IDLE) && !reset;
   assign ctrl.accept = req_tvalid && req_tready;
   // The result register can take a new word when it is empty or being drained.
   assign ctrl.load   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid  = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ctrl.load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = ctrl.load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> (state_ff == ST_EXEC))
      else $error("accepted word did not move the controller to execute");

   a_exec_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EXEC) && !ctrl.load) |=> (state_ff == ST_EXEC))
      else $error("pending result was dropped while the output was stalled");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// ===== hdl/bdq_dpath.sv =====
// Datapath: circular word store with front pointer and count, and the result register.
module bdq_dpath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bdq_pkg::ctrl_type                 ctrl,
   input  bdq_pkg::cmd_type                  req_cmd,
   input  logic signed [bdq_pkg::VALUE_W-1:0] req_value,
   output logic [bdq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bdq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W + 1)'(DEPTH);

   logic [VALUE_W-1:0] entry_mem [DEPTH];

   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0] rd_data_ff;
   status_type         status_ff, status_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               pop_ok_ff, pop_ok_in;
   logic [VALUE_W-1:0] rsp_value_ff;
   status_type         rsp_status_ff;
   logic [OCC_W-1:0]   rsp_occ_ff;

   logic               full, empty;
   logic               wr_en, rd_en;
   logic [PTR_W-1:0]   wr_addr, rd_addr;
   logic [PTR_W-1:0]   head_dec, head_inc, tail_idx, last_idx;
   logic [CNT_W:0]     tail_sum, last_sum;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   // Fold a sum below twice the depth back into the store's index range.
   function automatic logic [PTR_W-1:0] wrap_idx(input logic [CNT_W:0] s);
      logic [CNT_W:0] r;
      r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
      return r[PTR_W-1:0];
   endfunction

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   assign head_dec = (head_ff == '0) ? LAST_PTR : (head_ff - 1'b1);
   assign head_inc = (head_ff == LAST_PTR) ? '0 : (head_ff + 1'b1);
   assign tail_sum = (CNT_W + 1)'(head_ff) + (CNT_W + 1)'(count_ff);
   assign last_sum = tail_sum - 1'b1;
   assign tail_idx = wrap_idx(tail_sum);
   assign last_idx = wrap_idx(last_sum);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STATUS_DONE;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_idx;
      rd_addr   = head_ff;
      case (req_cmd)
         CMD_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = ctrl.accept;
               wr_addr  = head_dec;
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = ctrl.accept;
               wr_addr  = tail_idx;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en     = ctrl.accept;
               rd_addr   = head_ff;
               head_in   = head_inc;
               count_in  = count_ff - 1'b1;
               pop_ok_in = 1'b1;
            end
         end
         default: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en     = ctrl.accept;
               rd_addr   = last_idx;
               count_in  = count_ff - 1'b1;
               pop_ok_in = 1'b1;
            end
         end
      endcase
   end

   // Occupancy reports the low bits of the count only.
   assign occ_wide = (CNT_W + OCC_W)'(count_in);
   assign occ_in   = occ_wide[OCC_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) entry_mem[wr_addr] <= req_value;
      if (rd_en) rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (ctrl.accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         status_ff <= status_in;
         occ_ff    <= occ_in;
         pop_ok_ff <= pop_ok_in;
      end
      if (ctrl.load) begin
         rsp_value_ff  <= pop_ok_ff ? rd_data_ff : '0;
         rsp_status_ff <= status_ff;
         rsp_occ_ff    <= occ_ff;
      end
   end

   assign rsp_tdata = (RSP_DATA_W)'({rsp_occ_ff, rsp_status_ff, rsp_value_ff});

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("word count above capacity");

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_PTR)
      else $error("front pointer outside the store");

   a_refused_push_holds: assert property (@(posedge clock) disable iff (reset)
      (ctrl.accept && full && ((req_cmd == CMD_PUSH_FRONT) || (req_cmd == CMD_PUSH_BACK)))
      |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("refused push changed the deque");

endmodule
